// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the stack machine executor.
// Standalone header; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, skipped while reset is active
`define SME_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a property on every rising edge, reset included
`define SME_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define SME_ASSERT(label, clk, rst_n, prop)
`define SME_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- src/sme_pkg.sv -----
// Types and codes of the stack machine executor.
// No dependencies; used by stack_machine_executor.
package sme_pkg;

    // Fixed widths of the result fields
    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 6;
    localparam int SLOT_W  = 5;

    // Instruction codes
    typedef enum logic [2:0] {
        K_PUSH  = 3'd0,
        K_ADD   = 3'd1,
        K_SUB   = 3'd2,
        K_DUP   = 3'd3,
        K_SWAP  = 3'd4,
        K_DROP  = 3'd5,
        K_DUMP  = 3'd6,
        K_CLEAR = 3'd7
    } t_kind;

    // Sticky error codes
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2
    } t_err;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_SWAP2,
        S_DUP_W,
        S_TOP_RD,
        S_TOP_CAP,
        S_DUMP_RD,
        S_DUMP_CAP,
        S_OUT
    } t_state;

    // Input transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] push_value;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [1:0]                status;
        logic [DEPTH_W-1:0]        depth;
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         slot;
        logic                      has_value;
        logic                      last;
    } t_out;

endpackage

// ----- src/stack_machine_executor.sv -----
// Stack machine executor: sequencer, stack memory and shared adder.
// Depends on sme_pkg and assert_macros.svh.
//
// Usage:
//   Input channel i_in_valid / o_in_ready / i_in_data carries one decoded
//   instruction (kind, push_value). Output channel o_out_valid / i_out_ready /
//   o_out_data carries results (status, depth, value, slot, has_value, last).
//   One instruction is worked on at a time; o_in_ready is high only while
//   the sequencer waits for the next instruction.
// Timing:
//   The stack lives in a single-port-write, single-port-read memory with a
//   registered read. Each step updates the stack, then reads the top for
//   its result, which has no value when the stack is empty after the step
//   (clear, errors, empty dump). A dump reads and outputs each entry in
//   turn, bottom slot first. The block is ready again in the cycle after
//   the last result is taken; one adder serves.
// Reset: synchronous, active low; empties the stack and clears the error.
//   Stack memory contents are not cleared and need no clearing pass.
// Stall: a result holds on o_out_data until i_out_ready takes it; the
//   block waits and accepts nothing meanwhile.
`include "assert_macros.svh"

module stack_machine_executor #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sme_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sme_pkg::t_out o_out_data
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW      = $clog2(DEPTH + 1);
    localparam int VALUE_W = sme_pkg::VALUE_W;
    localparam int DEPTH_W = sme_pkg::DEPTH_W;
    localparam int SLOT_W  = sme_pkg::SLOT_W;

    // Control registers
    sme_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_sp, n_sp;
    sme_pkg::t_err   r_err, n_err;
    logic [PW-1:0]   r_idx, n_idx;

    // Payload registers
    sme_pkg::t_kind        r_kind, n_kind;
    logic [WORD_BITS-1:0]  r_a, n_a;
    sme_pkg::t_out         r_out, n_out;

    // Stack memory
    logic [WORD_BITS-1:0]  mem [DEPTH];
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [AW-1:0]         mem_raddr;

    // Derived values
    sme_pkg::t_kind        in_kind;
    logic [PW-1:0]         sp_m1, sp_m2;
    logic                  sp_full, sp_lt2, sp_zero;
    logic                  is_sub;
    logic [WORD_BITS-1:0]  alu_sum;
    logic                  dump_last;

    assign in_kind  = sme_pkg::t_kind'(i_in_data.kind);
    assign sp_m1    = r_sp - PW'(1);
    assign sp_m2    = r_sp - PW'(2);
    assign sp_full  = (r_sp == PW'(DEPTH));
    assign sp_lt2   = (r_sp < PW'(2));
    assign sp_zero  = (r_sp == '0);
    assign dump_last = ((r_idx + PW'(1)) == r_sp);

    // Shared adder: second + top, or second - top via inverted operand
    assign is_sub  = (r_kind == sme_pkg::K_SUB);
    assign alu_sum = r_rdata + (is_sub ? ~r_a : r_a) + WORD_BITS'(is_sub);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sme_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (in_kind == sme_pkg::K_CLEAR || r_err != sme_pkg::ERR_NONE) begin
                        n_state = sme_pkg::S_TOP_RD;
                    end else begin
                        case (in_kind)
                            sme_pkg::K_ADD, sme_pkg::K_SUB, sme_pkg::K_SWAP:
                                n_state = sp_lt2 ? sme_pkg::S_TOP_RD : sme_pkg::S_RD_A;
                            sme_pkg::K_DUP:
                                n_state = (sp_zero || sp_full) ? sme_pkg::S_TOP_RD
                                                               : sme_pkg::S_DUP_W;
                            sme_pkg::K_DUMP:
                                n_state = sp_zero ? sme_pkg::S_TOP_RD : sme_pkg::S_DUMP_RD;
                            default:
                                n_state = sme_pkg::S_TOP_RD;
                        endcase
                    end
                end
            end
            sme_pkg::S_RD_A:     n_state = sme_pkg::S_RD_B;
            sme_pkg::S_RD_B: begin
                n_state = (r_kind == sme_pkg::K_SWAP) ? sme_pkg::S_SWAP2 : sme_pkg::S_TOP_RD;
            end
            sme_pkg::S_SWAP2:    n_state = sme_pkg::S_TOP_RD;
            sme_pkg::S_DUP_W:    n_state = sme_pkg::S_TOP_RD;
            sme_pkg::S_TOP_RD:   n_state = sp_zero ? sme_pkg::S_OUT : sme_pkg::S_TOP_CAP;
            sme_pkg::S_TOP_CAP:  n_state = sme_pkg::S_OUT;
            sme_pkg::S_DUMP_RD:  n_state = sme_pkg::S_DUMP_CAP;
            sme_pkg::S_DUMP_CAP: n_state = sme_pkg::S_OUT;
            sme_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = r_out.last ? sme_pkg::S_IDLE : sme_pkg::S_DUMP_RD;
                end
            end
            default:             n_state = sme_pkg::S_IDLE;
        endcase
    end

    // Outputs, memory control and register updates
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        n_sp        = r_sp;
        n_err       = r_err;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_a         = r_a;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_sp[AW-1:0];
        mem_wdata   = r_rdata;
        mem_raddr   = sp_m1[AW-1:0];
        case (r_state)
            sme_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind = in_kind;
                    n_idx  = '0;
                    if (in_kind == sme_pkg::K_CLEAR) begin
                        n_sp  = '0;
                        n_err = sme_pkg::ERR_NONE;
                    end else if (r_err == sme_pkg::ERR_NONE) begin
                        case (in_kind)
                            sme_pkg::K_PUSH: begin
                                if (sp_full) begin
                                    n_sp  = '0;
                                    n_err = sme_pkg::ERR_OVER;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_wdata = WORD_BITS'(i_in_data.push_value);
                                    n_sp      = r_sp + PW'(1);
                                end
                            end
                            sme_pkg::K_ADD, sme_pkg::K_SUB, sme_pkg::K_SWAP: begin
                                if (sp_lt2) begin
                                    n_sp  = '0;
                                    n_err = sme_pkg::ERR_UNDER;
                                end
                            end
                            sme_pkg::K_DUP: begin
                                if (sp_zero) begin
                                    n_err = sme_pkg::ERR_UNDER;
                                end else if (sp_full) begin
                                    n_sp  = '0;
                                    n_err = sme_pkg::ERR_OVER;
                                end
                            end
                            sme_pkg::K_DROP: begin
                                if (sp_zero) begin
                                    n_err = sme_pkg::ERR_UNDER;
                                end else begin
                                    n_sp = sp_m1;
                                end
                            end
                            default: begin
                                // dump needs no update here
                            end
                        endcase
                    end
                end
            end
            sme_pkg::S_RD_A: begin
                // capture top, fetch second
                n_a       = r_rdata;
                mem_raddr = sp_m2[AW-1:0];
            end
            sme_pkg::S_RD_B: begin
                mem_we = 1'b1;
                if (r_kind == sme_pkg::K_SWAP) begin
                    mem_waddr = sp_m1[AW-1:0];
                    mem_wdata = r_rdata;
                end else begin
                    mem_waddr = sp_m2[AW-1:0];
                    mem_wdata = alu_sum;
                    n_sp      = sp_m1;
                end
            end
            sme_pkg::S_SWAP2: begin
                mem_we    = 1'b1;
                mem_waddr = sp_m2[AW-1:0];
                mem_wdata = r_a;
            end
            sme_pkg::S_DUP_W: begin
                mem_we    = 1'b1;
                mem_waddr = r_sp[AW-1:0];
                mem_wdata = r_rdata;
                n_sp      = r_sp + PW'(1);
            end
            sme_pkg::S_TOP_RD: begin
                // empty stack gives a result without a value
                n_out.status    = r_err;
                n_out.depth     = DEPTH_W'(r_sp);
                n_out.value     = '0;
                n_out.slot      = '0;
                n_out.has_value = 1'b0;
                n_out.last      = 1'b1;
            end
            sme_pkg::S_TOP_CAP: begin
                n_out.status    = r_err;
                n_out.depth     = DEPTH_W'(r_sp);
                n_out.value     = VALUE_W'($signed(r_rdata));
                n_out.slot      = '0;
                n_out.has_value = 1'b1;
                n_out.last      = 1'b1;
            end
            sme_pkg::S_DUMP_RD: begin
                mem_raddr = r_idx[AW-1:0];
            end
            sme_pkg::S_DUMP_CAP: begin
                n_out.status    = r_err;
                n_out.depth     = DEPTH_W'(r_sp);
                n_out.value     = VALUE_W'($signed(r_rdata));
                n_out.slot      = SLOT_W'(r_idx);
                n_out.has_value = 1'b1;
                n_out.last      = dump_last;
            end
            sme_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready && !r_out.last) begin
                    n_idx = r_idx + PW'(1);
                end
            end
            default: begin
                // unused state codes do nothing
            end
        endcase
    end

    assign o_out_data = r_out;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sme_pkg::S_IDLE;
            r_sp    <= '0;
            r_err   <= sme_pkg::ERR_NONE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_err   <= n_err;
            r_idx   <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_a    <= n_a;
        r_out  <= n_out;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Checks
    `SME_ASSERT(a_one_side, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `SME_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= PW'(DEPTH))
    `SME_ASSERT(a_err_empty, i_clk, i_rst_n, (r_err != sme_pkg::ERR_NONE) |-> sp_zero)
    `SME_ASSERT(a_no_value_zero, i_clk, i_rst_n, (o_out_valid && !o_out_data.has_value) |-> (o_out_data.value == '0))
    `SME_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)

endmodule
